// ----- hw/rtl/tbcld_pkg.sv -----
// ----------------------------------------------------------------------------
// tbcld_pkg
// Shared types and constants for the two-button chord and long-press detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbcld_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int MAX_EVENTS     = 4;
  localparam int EV_CNT_W       = 3;
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_CHORD_WINDOW = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS   = 2'd2;

  localparam logic [9:0]  DEBOUNCE_RST     = 10'd50;
  localparam logic [10:0] CHORD_WINDOW_RST = 11'd200;
  localparam logic [13:0] LONG_PRESS_RST   = 14'd1000;

  typedef enum logic [2:0] {
    EV_LEFT_PRESS  = 3'd0,
    EV_RIGHT_PRESS = 3'd1,
    EV_BOTH_PRESS  = 3'd2,
    EV_LEFT_LONG   = 3'd3,
    EV_RIGHT_LONG  = 3'd4
  } ev_code_t;

  typedef struct packed {
    logic left_level;
    logic right_level;
  } in_item_t;

  typedef struct packed {
    ev_code_t    event_code;
    logic [15:0] hold_dur;
    logic        left_down;
    logic        right_down;
    logic        chord_held;
    logic        last_event;
  } out_item_t;

  typedef out_item_t [MAX_EVENTS-1:0] ev_vec_t;

  typedef struct packed {
    logic [9:0]  dbnc_time;
    logic [10:0] chord_win;
    logic [13:0] hold_time;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tbcld_tick.sv -----
// ----------------------------------------------------------------------------
// tbcld_tick
// Per-tick processing: debounce, chord window, long-press timers and the list
// of events that one tick produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbcld_tick #(
  parameter int TIMER_BITS = tbcld_pkg::TIMER_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  tbcld_pkg::cfg_t                   cfg,
  input  wire                               tick_go,
  input  tbcld_pkg::in_item_t               tick_item,
  output tbcld_pkg::ev_vec_t                ev_vec,
  output logic [tbcld_pkg::EV_CNT_W-1:0]    ev_n
);

  import tbcld_pkg::*;

  localparam int TB = TIMER_BITS;

  logic [TB-1:0] ms_r, ms_nxt;
  logic [1:0]    prev_r, prev_nxt;
  logic [TB-1:0] last_r [2];
  logic [TB-1:0] last_nxt [2];
  logic [1:0]    held_r, held_nxt;
  logic [TB-1:0] press_r [2];
  logic [TB-1:0] press_nxt [2];
  logic [1:0]    lfired_r, lfired_nxt;
  logic [10:0]   chord_cd_r [2];
  logic [10:0]   chord_cd_nxt [2];
  logic [13:0]   long_cd_r [2];
  logic [13:0]   long_cd_nxt [2];
  logic          both_r, both_nxt;

  function automatic out_item_t mk_ev(ev_code_t code, logic [15:0] dur,
                                      logic [1:0] hv, logic bf);
    out_item_t e;
    e.event_code  = code;
    e.hold_dur    = dur;
    e.left_down   = hv[0];
    e.right_down  = hv[1];
    e.chord_held  = bf;
    e.last_event  = 1'b0;
    return e;
  endfunction

  always_comb begin
    logic          bi;
    logic          oi;
    logic [TB-1:0] age;
    logic [31:0]   dwide;
    logic [15:0]   dur;
    logic [13:0]   lpv;
    logic [1:0]    cdue;
    logic [1:0]    ldue;
    logic [1:0]    lv;

    ms_nxt      = ms_r + TB'(1);
    prev_nxt    = prev_r;
    last_nxt    = last_r;
    held_nxt    = held_r;
    press_nxt   = press_r;
    lfired_nxt  = lfired_r;
    chord_cd_nxt = chord_cd_r;
    long_cd_nxt = long_cd_r;
    both_nxt    = both_r;
    ev_vec      = '0;
    ev_n        = '0;
    cdue        = '0;
    ldue        = '0;
    lv          = {tick_item.right_level, tick_item.left_level};
    lpv         = (cfg.hold_time != '0) ? cfg.hold_time : 14'd1;

    // Countdowns run first; one that reaches zero in this tick is due.
    for (int i = 0; i < 2; i++) begin
      if (chord_cd_r[i] != '0) begin
        chord_cd_nxt[i] = chord_cd_r[i] - 11'd1;
        cdue[i]         = (chord_cd_r[i] == 11'd1);
      end
      if (long_cd_r[i] != '0) begin
        long_cd_nxt[i] = long_cd_r[i] - 14'd1;
        ldue[i]        = (long_cd_r[i] == 14'd1);
      end
    end

    // Edges, left before right.
    for (int i = 0; i < 2; i++) begin
      bi  = i[0];
      oi  = ~bi;
      age = ms_nxt - last_r[bi];
      if (lv[bi] != prev_r[bi]) begin
        prev_nxt[bi] = lv[bi];
        if (age >= {{(TB-10){1'b0}}, cfg.dbnc_time}) begin
          last_nxt[bi] = ms_nxt;
          if (!lv[bi]) begin
            held_nxt[bi]   = 1'b1;
            press_nxt[bi]  = ms_nxt;
            lfired_nxt[bi] = 1'b0;
            if (held_nxt[oi]) begin
              chord_cd_nxt[oi] = '0;
              cdue[oi]         = 1'b0;
              long_cd_nxt[0]   = '0;
              long_cd_nxt[1]   = '0;
              ldue             = '0;
              both_nxt         = 1'b1;
              if (ev_n < EV_CNT_W'(MAX_EVENTS)) begin
                ev_vec[ev_n[1:0]] = mk_ev(EV_BOTH_PRESS, 16'd0, held_nxt, both_nxt);
                ev_n = ev_n + EV_CNT_W'(1);
              end
            end else if (cfg.chord_win != '0) begin
              chord_cd_nxt[bi] = cfg.chord_win;
              cdue[bi]         = 1'b0;
            end else begin
              if (ev_n < EV_CNT_W'(MAX_EVENTS)) begin
                ev_vec[ev_n[1:0]] = mk_ev(bi ? EV_RIGHT_PRESS : EV_LEFT_PRESS,
                                          16'd0, held_nxt, both_nxt);
                ev_n = ev_n + EV_CNT_W'(1);
              end
              long_cd_nxt[bi] = lpv;
              ldue[bi]        = 1'b0;
            end
          end else begin
            held_nxt[bi]     = 1'b0;
            long_cd_nxt[bi]  = '0;
            chord_cd_nxt[bi] = '0;
            ldue[bi]         = 1'b0;
            cdue[bi]         = 1'b0;
            both_nxt         = 1'b0;
          end
        end
      end
    end

    // Chord window ran out with no second press: report the single press.
    for (int i = 0; i < 2; i++) begin
      bi = i[0];
      if (cdue[bi] && held_nxt[bi] && !both_nxt) begin
        if (ev_n < EV_CNT_W'(MAX_EVENTS)) begin
          ev_vec[ev_n[1:0]] = mk_ev(bi ? EV_RIGHT_PRESS : EV_LEFT_PRESS,
                                    16'd0, held_nxt, both_nxt);
          ev_n = ev_n + EV_CNT_W'(1);
        end
        long_cd_nxt[bi] = lpv;
        ldue[bi]        = 1'b0;
      end
    end

    // Long-press expiries; the duration saturates at 16 bits.
    for (int i = 0; i < 2; i++) begin
      bi    = i[0];
      dwide = 32'(ms_nxt - press_nxt[bi]);
      dur   = (|dwide[31:16]) ? 16'hFFFF : dwide[15:0];
      if (ldue[bi] && held_nxt[bi] && !lfired_nxt[bi]) begin
        lfired_nxt[bi] = 1'b1;
        if (!both_nxt && (ev_n < EV_CNT_W'(MAX_EVENTS))) begin
          ev_vec[ev_n[1:0]] = mk_ev(bi ? EV_RIGHT_LONG : EV_LEFT_LONG,
                                    dur, held_nxt, both_nxt);
          ev_n = ev_n + EV_CNT_W'(1);
        end
      end
    end

    for (int i = 0; i < MAX_EVENTS; i++) begin
      if ((ev_n != '0) && (EV_CNT_W'(i) == ev_n - EV_CNT_W'(1))) begin
        ev_vec[i].last_event = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r     <= '0;
      prev_r   <= 2'b11;
      held_r   <= '0;
      lfired_r <= '0;
      both_r   <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        last_r[i]     <= '0;
        press_r[i]    <= '0;
        chord_cd_r[i] <= '0;
        long_cd_r[i]  <= '0;
      end
    end else if (tick_go) begin
      ms_r       <= ms_nxt;
      prev_r     <= prev_nxt;
      held_r     <= held_nxt;
      lfired_r   <= lfired_nxt;
      both_r     <= both_nxt;
      last_r     <= last_nxt;
      press_r    <= press_nxt;
      chord_cd_r <= chord_cd_nxt;
      long_cd_r  <= long_cd_nxt;
    end
  end

  // A chord can only be on while both buttons are held.
  a_both_held: assert property (@(posedge clk) disable iff (!rst_n)
    both_r |-> (held_r == 2'b11))
    else $error("chord flag set without both buttons held");

  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    ((long_cd_r[0] == '0) || held_r[0]) && ((long_cd_r[1] == '0) || held_r[1]))
    else $error("long-press timer running on a released button");

  a_chord_held: assert property (@(posedge clk) disable iff (!rst_n)
    ((chord_cd_r[0] == '0) || held_r[0]) && ((chord_cd_r[1] == '0) || held_r[1]))
    else $error("chord window open on a released button");

endmodule

`default_nettype wire

// ----- hw/rtl/tbcld_evq.sv -----
// ----------------------------------------------------------------------------
// tbcld_evq
// Event buffer: holds the events of one tick and hands them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbcld_evq (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             load,
  input  tbcld_pkg::ev_vec_t              ev_vec,
  input  wire [tbcld_pkg::EV_CNT_W-1:0]   ev_n,
  output logic                            ld_ok,
  output logic                            out_valid,
  input  wire                             out_stall,
  output tbcld_pkg::out_item_t            out_item
);

  import tbcld_pkg::*;

  out_item_t             buf_r [MAX_EVENTS];
  logic [EV_CNT_W-1:0]   cnt_r;
  logic [1:0]            rd_r;
  logic                  pop;
  logic                  last_pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = buf_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign last_pop  = pop && (({1'b0, rd_r} + EV_CNT_W'(1)) == cnt_r);
  // The next tick may load as the last event of this one leaves.
  assign ld_ok     = (cnt_r == '0) || last_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (load) begin
      cnt_r <= ev_n;
      rd_r  <= '0;
    end else if (last_pop) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (pop) begin
      rd_r  <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
        buf_r[i] <= ev_vec[i];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EV_CNT_W'(MAX_EVENTS))
    else $error("event count out of range");

  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ld_ok)
    else $error("event buffer loaded while still holding events");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, rd_r} < cnt_r))
    else $error("read pointer past event count");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_event) |-> (({1'b0, rd_r} + EV_CNT_W'(1)) == cnt_r))
    else $error("last-event flag not on the final event of a tick");

endmodule

`default_nettype wire

// ----- hw/rtl/two_button_chord_long_press_detector_core.sv -----
// ----------------------------------------------------------------------------
// two_button_chord_long_press_detector_core
// Two-button debounce, chord and long-press detector with APB-style config.
// ----------------------------------------------------------------------------
// Usage: send one item per millisecond tick on the in_ channel carrying both
// active-low pin levels. Each tick yields zero to four events on the out_
// channel; last_event marks the final event of a tick, and a tick with no
// event yields nothing. Registers: debounce time at 0x0, chord window at
// 0x4, long-press time at 0x8; write them only while the block is idle.
// Path: an accepted item is held in the input register, and its events are
// then loaded into the event buffer register that drives out_item.
// Throughput: one item per cycle while each tick yields at most one event and
// the receiver does not stall; a tick with more events, up to four, holds the
// single result port, and the input register waits until the last is taken.
// Reset: registers return to 50, 200 and 1000, the millisecond counter and
// all timers clear, and both buttons are taken as released.
// When the receiver stalls, the current event holds; the input register
// fills and in_stall rises, so no item or event is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_button_chord_long_press_detector_core #(
  parameter int TIMER_BITS = tbcld_pkg::TIMER_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  tbcld_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  wire                              out_stall,
  output tbcld_pkg::out_item_t             out_item,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tbcld_pkg::CFG_AW-1:0]      paddr,
  input  wire [tbcld_pkg::CFG_DW-1:0]      pwdata,
  output logic [tbcld_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready
);

  import tbcld_pkg::*;

  cfg_t                cfg_r;
  logic                in_vld_r;
  in_item_t            in_item_r;
  logic                ld_ok;
  logic                adv;
  ev_vec_t             ev_vec;
  logic [EV_CNT_W-1:0] ev_n;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dbnc_time <= DEBOUNCE_RST;
      cfg_r.chord_win <= CHORD_WINDOW_RST;
      cfg_r.hold_time <= LONG_PRESS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DEBOUNCE:     cfg_r.dbnc_time <= pwdata[9:0];
        REG_CHORD_WINDOW: cfg_r.chord_win <= pwdata[10:0];
        REG_LONG_PRESS:   cfg_r.hold_time <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEBOUNCE:     prdata = CFG_DW'(cfg_r.dbnc_time);
      REG_CHORD_WINDOW: prdata = CFG_DW'(cfg_r.chord_win);
      REG_LONG_PRESS:   prdata = CFG_DW'(cfg_r.hold_time);
      default:          prdata = '0;
    endcase
  end

  // The held tick is processed when the event buffer can take its events.
  assign adv      = in_vld_r && ld_ok;
  assign in_stall = in_vld_r && !ld_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
  end

  tbcld_tick #(
    .TIMER_BITS(TIMER_BITS)
  ) u_tick (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .tick_go   (adv),
    .tick_item (in_item_r),
    .ev_vec    (ev_vec),
    .ev_n      (ev_n)
  );

  tbcld_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .ev_vec    (ev_vec),
    .ev_n      (ev_n),
    .ld_ok     (ld_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
